[rtl/aip_pkg.sv]
`timescale 1ns / 1ps
// aip_pkg: shared types and constants of the ascii integer literal parser
// depends on nothing; imported by every rtl module and the checker

package aip_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_TILDE  = 8'h7e;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_X_UP   = 8'h58;
  localparam logic [7:0] CH_X_LOW  = 8'h78;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SIGNED = 3'd1,
    PH_ZERO   = 3'd2,
    PH_DEC    = 3'd3,
    PH_HEX    = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    SG_NONE = 2'd0,
    SG_NEG  = 2'd1,
    SG_INV  = 2'd2
  } sign_e;

  typedef enum logic [1:0] {
    OP_COMPOSE = 2'd0,
    OP_FINISH  = 2'd1,
    OP_BOTH    = 2'd2
  } op_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_SUM   = 2'd1,
    BK_APPLY = 2'd2
  } bk_state_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last;
  } aip_in_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [7:0]         consumed;
  } aip_out_t;

  typedef struct packed {
    op_kind_e    kind;
    sign_e       sign;
    logic [63:0] factor;
    logic [7:0]  consumed;
  } aip_op_t;

endpackage

[rtl/aip_front.sv]
`timescale 1ns / 1ps
// aip_front: per-character scanner; tracks phase, sign, factor digits and count
// depends on aip_pkg; pushes compose and finish requests toward aip_queue

module aip_front import aip_pkg::*; #(
  parameter int unsigned HEX_DIGITS = 8,
  parameter int unsigned COUNT_MAX  = 255
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  aip_in_t in_data_i,
  input  logic    q_full_i,
  output logic    push_o,
  output aip_op_t op_o
);

  localparam int unsigned CW = $clog2(COUNT_MAX + 1);
  localparam int unsigned HW = $clog2(HEX_DIGITS + 1);

  phase_e      phase_q, phase_d;
  sign_e       sign_q, sign_d;
  logic [63:0] factor_q, factor_d;
  logic [HW-1:0] hex_q, hex_d;
  logic [CW-1:0] count_q, count_d;
  logic        sent_q, sent_d;

  logic        fire;
  logic        ended;
  logic        compose;
  logic        bump;
  logic        done;
  logic        blank;
  logic        is_hex;
  logic [3:0]  hex_val;
  logic [CW-1:0] count_b;
  logic [HW:0] hex_next;

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && in_ready_o;
  assign blank      = (in_data_i.char_in inside {[8'd1:8'd32]});
  assign hex_next   = {1'b0, hex_q} + (HW+1)'(1);

  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'h0;
    case (in_data_i.char_in) inside
      [8'h30:8'h39]: hex_val = 4'(in_data_i.char_in - 8'h30);
      [8'h41:8'h46]: hex_val = 4'(in_data_i.char_in - 8'h37);
      [8'h61:8'h66]: hex_val = 4'(in_data_i.char_in - 8'h57);
      default:       is_hex  = 1'b0;
    endcase
  end

  // scan one character, with the fall-through between phases
  always_comb begin
    phase_d  = phase_q;
    sign_d   = sign_q;
    factor_d = factor_q;
    hex_d    = hex_q;
    ended    = 1'b0;
    compose  = 1'b0;
    bump     = 1'b0;
    done     = 1'b0;
    if (phase_d == PH_START) begin
      if (blank) begin
        bump = 1'b1;
        done = 1'b1;
      end else if (in_data_i.char_in == CH_MINUS) begin
        sign_d  = SG_NEG;
        bump    = 1'b1;
        phase_d = PH_SIGNED;
        done    = 1'b1;
      end else if (in_data_i.char_in == CH_TILDE) begin
        sign_d  = SG_INV;
        bump    = 1'b1;
        phase_d = PH_SIGNED;
        done    = 1'b1;
      end else begin
        phase_d = PH_SIGNED;
      end
    end
    if (!done && phase_d == PH_SIGNED) begin
      if (in_data_i.char_in == CH_DOLLAR) begin
        bump    = 1'b1;
        hex_d   = '0;
        phase_d = PH_HEX;
        done    = 1'b1;
      end else if (in_data_i.char_in == CH_ZERO) begin
        bump    = 1'b1;
        phase_d = PH_ZERO;
        done    = 1'b1;
      end else begin
        phase_d = PH_DEC;
      end
    end
    if (!done && phase_d == PH_ZERO) begin
      if (in_data_i.char_in == CH_X_UP || in_data_i.char_in == CH_X_LOW) begin
        bump    = 1'b1;
        hex_d   = '0;
        phase_d = PH_HEX;
        done    = 1'b1;
      end else begin
        phase_d = PH_DEC;
      end
    end
    if (!done) begin
      case (phase_d)
        PH_DEC: begin
          if (in_data_i.char_in inside {[8'h30:8'h39]}) begin
            factor_d = (factor_q << 3) + (factor_q << 1) + 64'(hex_val);
            bump     = 1'b1;
          end else if (in_data_i.char_in == CH_STAR) begin
            compose  = 1'b1;
            bump     = 1'b1;
            sign_d   = SG_NONE;
            factor_d = '0;
            phase_d  = PH_START;
          end else begin
            ended = 1'b1;
          end
        end
        PH_HEX: begin
          if (hex_q == '0 && blank) begin
            bump = 1'b1;
          end else if (is_hex) begin
            factor_d = {factor_q[59:0], hex_val};
            bump     = 1'b1;
            hex_d    = hex_next[HW-1:0];
            ended    = (hex_next >= (HW+1)'(HEX_DIGITS));
          end else begin
            ended = 1'b1;
          end
        end
        default: ended = 1'b1;
      endcase
    end
  end

  assign count_b = (bump && count_q != CW'(COUNT_MAX)) ? count_q + CW'(1) : count_q;

  always_comb begin
    push_o      = 1'b0;
    sent_d      = sent_q;
    op_o.sign   = sign_q;
    op_o.factor = compose ? factor_q : factor_d;
    op_o.consumed = 8'(count_b);
    op_o.kind   = OP_FINISH;
    if (compose && (ended || in_data_i.last)) begin
      op_o.kind = OP_BOTH;
    end else if (compose) begin
      op_o.kind = OP_COMPOSE;
    end
    if (!compose) begin
      op_o.sign = sign_d;
    end
    if (fire && !sent_q) begin
      push_o = compose || ended || in_data_i.last;
      sent_d = ended || in_data_i.last;
    end
    if (fire && in_data_i.last) begin
      sent_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      sign_q   <= SG_NONE;
      factor_q <= '0;
      hex_q    <= '0;
      count_q  <= '0;
      sent_q   <= 1'b0;
    end else if (fire) begin
      sent_q <= sent_d;
      if (in_data_i.last) begin
        phase_q  <= PH_START;
        sign_q   <= SG_NONE;
        factor_q <= '0;
        hex_q    <= '0;
        count_q  <= '0;
      end else if (!sent_q) begin
        phase_q  <= phase_d;
        sign_q   <= sign_d;
        factor_q <= factor_d;
        hex_q    <= hex_d;
        count_q  <= count_b;
      end
    end
  end

endmodule

[rtl/aip_queue.sv]
`timescale 1ns / 1ps
// aip_queue: short first-in first-out queue of requests between front and back
// depends on aip_pkg for the request struct and its depth

module aip_queue import aip_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  aip_op_t op_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    empty_o,
  output aip_op_t head_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  aip_op_t     mem_q [QUEUE_DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   fill_q;

  assign full_o  = (fill_q == (AW+1)'(QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + AW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + (AW+1)'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - (AW+1)'(1);
      end
    end
  end

endmodule

[rtl/aip_back.sv]
`timescale 1ns / 1ps
// aip_back: holds the running affine map and applies queued requests
// depends on aip_pkg; requests step through idle, sum and apply; 32x32 partial products

module aip_back import aip_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     empty_i,
  input  aip_op_t  head_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output aip_out_t out_data_o
);

  bk_state_e   state_q, state_d;
  aip_op_t     op_q;
  logic [63:0] scale_q, scale_d;
  logic [63:0] offset_q, offset_d;
  logic [63:0] pll_q;
  logic [31:0] lh_q, hl_q;
  logic [63:0] p_q;
  logic [63:0] adj_q;
  logic        out_valid_q;
  aip_out_t    out_q;

  logic [63:0] pll_full;
  logic [31:0] lh_full, hl_full;
  logic        neg;
  logic [63:0] res;
  logic        slot_free;
  logic        load_out;
  logic        map_en;

  assign pll_full  = scale_q[31:0] * head_i.factor[31:0];
  assign lh_full   = scale_q[31:0] * head_i.factor[63:32];
  assign hl_full   = scale_q[63:32] * head_i.factor[31:0];
  assign neg       = (op_q.sign == SG_NEG) || (op_q.sign == SG_INV);
  assign res       = neg ? adj_q - p_q : adj_q + p_q;
  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    map_en   = 1'b0;
    scale_d  = scale_q;
    offset_d = offset_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = BK_SUM;
        end
      end
      BK_SUM: begin
        state_d = BK_APPLY;
      end
      BK_APPLY: begin
        if (op_q.kind == OP_COMPOSE) begin
          map_en   = 1'b1;
          scale_d  = neg ? 64'd0 - p_q : p_q;
          offset_d = adj_q;
          state_d  = BK_IDLE;
        end else if (slot_free) begin
          load_out = 1'b1;
          map_en   = 1'b1;
          scale_d  = 64'd1;
          offset_d = '0;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      op_q  <= head_i;
      pll_q <= pll_full;
      lh_q  <= lh_full;
      hl_q  <= hl_full;
    end
    if (state_q == BK_SUM) begin
      p_q   <= pll_q + {lh_q + hl_q, 32'h0};
      adj_q <= (op_q.sign == SG_INV) ? offset_q - scale_q : offset_q;
    end
    if (load_out) begin
      out_q.value    <= (op_q.kind == OP_BOTH) ? adj_q : res;
      out_q.consumed <= op_q.consumed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q     <= 64'd1;
      offset_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (map_en) begin
        scale_q  <= scale_d;
        offset_q <= offset_d;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/ascii_integer_literal_parser_top.sv]
`timescale 1ns / 1ps
// channel  dir  handshake                 payload
// in       in   in_valid_i / in_ready_o   aip_in_t  {char_in, last}
// out      out  out_valid_o / out_ready_i aip_out_t {value, consumed}
//
// one character per cycle enters the scanner while the queue has room, digits included
// each '*' in a decimal factor and each string end becomes a request; the map unit
// applies it by partial products, sum and apply; four requests queue between them
// the scanner stalls only when the request queue is full
// reset clears scanner state, the queue and the map (scale one, offset zero)
// a held result stalls the map unit; the scanner runs on until the queue fills

module ascii_integer_literal_parser_top import aip_pkg::*; #(
  parameter int unsigned HEX_DIGITS = 8,
  parameter int unsigned COUNT_MAX  = 255
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  aip_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output aip_out_t out_data_o
);

  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_empty;
  aip_op_t push_op;
  aip_op_t head_op;

  aip_front #(
    .HEX_DIGITS (HEX_DIGITS),
    .COUNT_MAX  (COUNT_MAX)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .op_o       (push_op)
  );

  aip_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head_op)
  );

  aip_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head_op),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/aip_checker.sv]
`timescale 1ns / 1ps
// aip_checker: port-level checks of the parser over time
// depends on aip_pkg; bound to ascii_integer_literal_parser_top below

module aip_checker import aip_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input aip_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input aip_out_t out_data_o
);

  logic              last_acc;
  logic              out_acc;
  logic signed [4:0] owed_q;

  assign last_acc = in_valid_i && in_ready_o && in_data_i.last;
  assign out_acc  = out_valid_o && out_ready_i;

  // strings ended minus results delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q <= '0;
    end else if (last_acc && !out_acc) begin
      owed_q <= owed_q + 5'sd1;
    end else if (out_acc && !last_acc) begin
      owed_q <= owed_q - 5'sd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    owed_q >= -5'sd1)
    else $error("more results than strings");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    owed_q <= 5'sd8)
    else $error("too many results outstanding");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result shown right after reset");

endmodule

bind ascii_integer_literal_parser_top aip_checker u_aip_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
